/* hdl/rbb_pkg.sv */
// Shared constants, register codes and the lane control bundle for the
// horizontal box blur. No dependencies; every other file imports this package.
package rbb_pkg;

  localparam int MAX_RADIUS    = 16;
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int STORE_DEPTH   = 2 * MAX_RADIUS + 1;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W    = RAD_W + 1;
  localparam int IDX_W    = $clog2(STORE_DEPTH);
  localparam int COL_W    = 13;
  localparam int RADIUS_W = 6;
  localparam int RECIP_W  = 17;
  localparam int SUM_W    = 15;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int FRAC_W   = 16;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [RADIUS_W-1:0] RADIUS_RST    = RADIUS_W'(1);
  localparam logic [COL_W-1:0]    ROW_WIDTH_RST = COL_W'(640);
  localparam logic [RECIP_W-1:0]  RECIP_RST     = RECIP_W'(21845);
  localparam logic [COL_W-1:0]    ROW_WIDTH_MAX = COL_W'(MAX_ROW_WIDTH);
  localparam logic [PROD_W:0]     ROUND_HALF    = (PROD_W + 1)'(1) << (FRAC_W - 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIUS    = 2'd0,
    REG_ROW_WIDTH = 2'd1,
    REG_RECIP     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             step;
    logic             init;
    logic [WIN_W-1:0] win;
    logic             adv_p;
    logic             adv_o;
  } lane_ctl_t;

endpackage

/* hdl/running_box_blur_row.sv */
// Top level of the horizontal RGBA box blur: configuration registers, row
// control, the pixel delay line of rbb_cell stages and four rbb_lane channels.
//
// Usage: pixels of a row arrive on the slave side, red in the low byte of
// s_tdata. Each result is the window mean of 2*radius+1 pixels, with the row's
// first and last pixel standing in beyond its ends; m_tlast marks the last
// result of a row. The first radius pixels of a row give no result; the last
// pixel of a row gives radius+1 results.
// Throughput: one pixel per cycle inside a row, unless the master side stalls.
// After the last pixel of a row s_tready stays low for radius flush steps while
// the end-of-row results are made from the held last pixel; this flush sets the
// row-to-row gap. A result passes from the window sums through the sum stage,
// product stage and output register to the master side.
// A stalled master side fills the three stages, then s_tready drops; each
// stage still moves when the one after it is empty.
// Configuration is written through cfg_we/cfg_addr/cfg_data while no results
// are pending. Reset restores radius 1, row width 640, factor 21845, starts a
// new row and empties the pipeline.
module running_box_blur_row (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rbb_pkg::PIX_W-1:0]    s_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rbb_pkg::PIX_W-1:0]    m_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic                         m_tlast,
  input  logic                         cfg_we,
  input  logic [rbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbb_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic [COL_W-1:0]    row_width;
  logic [RECIP_W-1:0]  recip;

  logic [RAD_W-1:0] r_eff;
  logic [WIN_W-1:0] win;
  logic [COL_W-1:0] w_eff;

  logic             flushing;
  logic [RAD_W-1:0] flush_s;
  logic [COL_W-1:0] fpos;
  logic [COL_W-1:0] col;
  logic [PIX_W-1:0] first_pix;
  logic [PIX_W-1:0] last_pix;

  logic svalid, seor, pvalid, peor, ovalid, oeor;
  logic adv_s, adv_p, adv_o;
  logic in_xfer, fl_step, step, init, emit, eor, last_col, use_first;

  logic [IDX_W-1:0] tap_idx;
  logic [PIX_W-1:0] cell_pix [STORE_DEPTH];
  logic [PIX_W-1:0] cell_tap [STORE_DEPTH];
  logic [PIX_W-1:0] tap_or;
  logic [PIX_W-1:0] enter_pix;
  logic [PIX_W-1:0] leave_pix;
  logic [PIX_W-1:0] result;

  lane_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RST;
      row_width <= ROW_WIDTH_RST;
      recip     <= RECIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RADIUS:    radius    <= cfg_data[RADIUS_W-1:0];
        REG_ROW_WIDTH: row_width <= cfg_data[COL_W-1:0];
        REG_RECIP:     recip     <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    r_eff = (radius > RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius[RAD_W-1:0];
    win   = {r_eff, 1'b1};
    if (row_width == '0) begin
      w_eff = COL_W'(1);
    end else if (row_width > ROW_WIDTH_MAX) begin
      w_eff = ROW_WIDTH_MAX;
    end else begin
      w_eff = row_width;
    end
  end

  assign adv_o    = !ovalid || m_tready;
  assign adv_p    = !pvalid || adv_o;
  assign adv_s    = !svalid || adv_p;
  assign s_tready = adv_s && !flushing;
  assign in_xfer  = s_tvalid && s_tready;
  assign fl_step  = flushing && adv_s;
  assign step     = in_xfer || fl_step;
  assign init     = in_xfer && (col == '0);
  assign last_col = col >= (w_eff - COL_W'(1));

  always_comb begin
    if (flushing) begin
      emit      = fpos >= COL_W'(r_eff);
      eor       = flush_s == r_eff;
      use_first = fpos < COL_W'(win);
      tap_idx   = IDX_W'(win - WIN_W'(flush_s));
      enter_pix = last_pix;
    end else begin
      emit      = col >= COL_W'(r_eff);
      eor       = last_col && (r_eff == '0);
      use_first = col < COL_W'(win);
      tap_idx   = IDX_W'(win - WIN_W'(1));
      enter_pix = s_tdata;
    end
  end

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    rbb_cell u_cell (
      .clk    (clk),
      .shift  (in_xfer),
      .pix_in ((k == 0) ? s_tdata : cell_pix[(k == 0) ? 0 : k - 1]),
      .sel    (tap_idx == IDX_W'(k)),
      .pix    (cell_pix[k]),
      .tap    (cell_tap[k])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      tap_or = tap_or | cell_tap[k];
    end
  end

  assign leave_pix = use_first ? first_pix : tap_or;

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
      flush_s  <= '0;
      fpos     <= '0;
      col      <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col <= '0;
        if (r_eff != '0) begin
          flushing <= 1'b1;
          flush_s  <= RAD_W'(1);
          fpos     <= col + COL_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end else if (fl_step) begin
      if (flush_s == r_eff) begin
        flushing <= 1'b0;
      end
      flush_s <= flush_s + RAD_W'(1);
      fpos    <= fpos + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_pix <= s_tdata;
      if (col == '0) begin
        first_pix <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= 1'b0;
      pvalid <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (adv_s) begin
        svalid <= step && emit;
      end
      if (adv_p) begin
        pvalid <= svalid;
      end
      if (adv_o) begin
        ovalid <= pvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      seor <= eor;
    end
    if (adv_p) begin
      peor <= seor;
    end
    if (adv_o) begin
      oeor <= peor;
    end
  end

  assign ctl.step  = step;
  assign ctl.init  = init;
  assign ctl.win   = win;
  assign ctl.adv_p = adv_p;
  assign ctl.adv_o = adv_o;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rbb_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .enter  (enter_pix[c*CH_W +: CH_W]),
      .leave  (leave_pix[c*CH_W +: CH_W]),
      .recip  (recip),
      .result (result[c*CH_W +: CH_W])
    );
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = result;
  assign m_tlast  = oeor;

  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last_col && r_eff != '0) |=> flushing)
    else $error("flush did not start after the last pixel of a row");

  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (flush_s != '0 && flush_s <= r_eff))
    else $error("flush step count out of range");

  a_hold_sums: assert property (@(posedge clk) disable iff (rst)
    (svalid && !adv_p) |-> !step)
    else $error("window sums stepped while a result was held");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (step && eor) |=> svalid)
    else $error("end-of-row step produced no result");

endmodule

/* hdl/rbb_cell.sv */
// One stage of the pixel delay line: holds a packed pixel, hands it to the
// next stage on every input transfer, and drives it onto the tap bus when selected.
module rbb_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [rbb_pkg::PIX_W-1:0] pix_in,
  input  logic                      sel,
  output logic [rbb_pkg::PIX_W-1:0] pix,
  output logic [rbb_pkg::PIX_W-1:0] tap
);
  import rbb_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      pix <= pix_in;
    end
  end

  assign tap = sel ? pix : '0;

endmodule

/* hdl/rbb_lane.sv */
// One color channel: running window sum, Q16 scaling and rounding with
// saturation, over the sum, product and output stages. Uses rbb_pkg.
module rbb_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  rbb_pkg::lane_ctl_t          ctl,
  input  logic [rbb_pkg::CH_W-1:0]    enter,
  input  logic [rbb_pkg::CH_W-1:0]    leave,
  input  logic [rbb_pkg::RECIP_W-1:0] recip,
  output logic [rbb_pkg::CH_W-1:0]    result
);
  import rbb_pkg::*;

  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     rounded;
  logic [PROD_W-FRAC_W:0] scaled;

  always_comb begin
    if (ctl.init) begin
      sum_next = SUM_W'(SUM_W'(ctl.win) * SUM_W'(enter));
    end else begin
      sum_next = SUM_W'(sum + SUM_W'(enter) - SUM_W'(leave));
    end
  end

  assign rounded = {1'b0, prod} + ROUND_HALF;
  assign scaled  = rounded[PROD_W:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.step) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_p) begin
      prod <= PROD_W'(sum) * PROD_W'(recip);
    end
    if (ctl.adv_o) begin
      result <= (scaled > (PROD_W - FRAC_W + 1)'(255)) ? '1 : scaled[CH_W-1:0];
    end
  end

endmodule
